### rtl/wpi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_pkg
// Shared types and constants of the waypoint path interpolator.
// ----------------------------------------------------------------------------
package wpi_pkg;

    localparam int COORD_W   = 32;
    localparam int TIME_W    = 32;
    localparam int TGT_IN_W  = 4;
    localparam int PT_IN_W   = 6;
    // Path length field, wide enough for the largest supported path (64 points)
    localparam int LEN_MAX_W = 13;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int DVD_W     = 65;
    localparam int DSR_W     = 32;

    localparam logic [31:0] STEP_ONE = 32'h0001_0000;
    localparam logic [31:0] STEP_MIN = 32'd7;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Classified work item
    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_QERR,
        KIND_QRUN
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [TGT_IN_W-1:0]    target;
        logic [PT_IN_W-1:0]     point_index;
        logic [LEN_MAX_W-1:0]   len;
        logic [COORD_W-1:0]     coord_x;
        logic [COORD_W-1:0]     coord_y;
        logic [TIME_W-1:0]      time_req;
    } q_item_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage : wpi_pkg
`default_nettype wire

### rtl/wpi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_front
// Accepts input beats, keeps the path lengths and classifies each item.
// ----------------------------------------------------------------------------
module wpi_front
    import wpi_pkg::*;
#(
    parameter int NUM_TARGETS = 16,
    parameter int MAX_POINTS  = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_cmd,
    input  wire logic [TGT_IN_W-1:0] s_target,
    input  wire logic [PT_IN_W-1:0]  s_point_index,
    input  wire logic                s_last_point,
    input  wire logic [COORD_W-1:0]  s_coord_x,
    input  wire logic [COORD_W-1:0]  s_coord_y,
    input  wire logic [TIME_W-1:0]   s_time_req,
    input  wire q_stat_t             q_stat,
    output logic                     q_push,
    output q_item_t                  q_item
);

    localparam int TGT_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int LEN_W = $clog2(MAX_POINTS + 1);

    logic [LEN_W-1:0] path_len_reg [NUM_TARGETS];

    logic [8:0]       tgt_ext;
    logic [12:0]      pt_ext;
    logic             tgt_ok;
    logic             pt_ok;
    logic [TGT_W-1:0] tgt_idx;
    logic [LEN_W-1:0] len_cur;
    logic             accept;
    logic             load_ok;

    // Range checks on the slot
    always_comb begin
        tgt_ext = 9'(s_target);
        pt_ext  = 13'(s_point_index);
        tgt_ok  = tgt_ext < 9'(NUM_TARGETS);
        pt_ok   = pt_ext < 13'(MAX_POINTS);
        tgt_idx = tgt_ext[TGT_W-1:0];
        len_cur = tgt_ok ? path_len_reg[tgt_idx] : '0;
    end

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign load_ok = (s_cmd == CMD_LOAD) && tgt_ok && pt_ok;
    // Loads to a bad slot are dropped here
    assign q_push  = accept && ((s_cmd == CMD_QUERY) || load_ok);

    // Classify
    always_comb begin
        q_item.target      = s_target;
        q_item.point_index = s_point_index;
        q_item.len         = LEN_MAX_W'(len_cur);
        q_item.coord_x     = s_coord_x;
        q_item.coord_y     = s_coord_y;
        q_item.time_req    = s_time_req;
        if (s_cmd == CMD_LOAD) begin
            q_item.kind = KIND_LOAD;
        end else if (!tgt_ok || (len_cur == '0)) begin
            q_item.kind = KIND_QERR;
        end else begin
            q_item.kind = KIND_QRUN;
        end
    end

    // Path length table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TARGETS; i++) begin
                path_len_reg[i] <= '0;
            end
        end else if (accept && load_ok && s_last_point) begin
            path_len_reg[tgt_idx] <= LEN_W'(pt_ext + 13'd1);
        end
    end

endmodule : wpi_front
`default_nettype wire

### rtl/wpi_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module wpi_fifo
    import wpi_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire q_item_t push_item,
    input  wire logic    pop,
    output q_item_t      head_item,
    output q_stat_t      stat
);

    q_item_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;

    assign head_item  = mem_reg[rd_ptr_reg];
    assign stat.full  = count_reg == (Q_PTR_W + 1)'(Q_DEPTH);
    assign stat.empty = count_reg == '0;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule : wpi_fifo
`default_nettype wire

### rtl/wpi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpi_div
    import wpi_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient,
    output logic [DSR_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] q_reg;
    logic [DSR_W-1:0] r_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DSR_W:0]   trial;
    logic             ge;

    assign trial     = {r_reg, q_reg[DVD_W-1]};
    assign ge        = trial >= {1'b0, dsr_reg};
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            r_reg   <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[DVD_W-2:0], ge};
            r_reg <= ge ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
        end
    end

    // Bit counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule : wpi_div
`default_nettype wire

### rtl/wpi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_back
// Executes queued items: waypoint writes and interpolation queries.
// ----------------------------------------------------------------------------
module wpi_back
    import wpi_pkg::*;
#(
    parameter int NUM_TARGETS = 16,
    parameter int MAX_POINTS  = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [31:0]        step_period,
    input  wire q_item_t            head_item,
    input  wire q_stat_t            q_stat,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COORD_W-1:0]      m_pos_x,
    output logic [COORD_W-1:0]      m_pos_y,
    output logic [COORD_W-1:0]      m_vel_x,
    output logic [COORD_W-1:0]      m_vel_y,
    output logic                    m_status
);

    localparam int DEPTH  = NUM_TARGETS * MAX_POINTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PT_W   = $clog2(MAX_POINTS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRITE, ST_DIV, ST_WAIT, ST_RD_CUR, ST_RD_NXT,
        ST_DIFF, ST_MUL_LO, ST_MUL_HI, ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        OP_TIME, OP_MOD, OP_POS, OP_VEL
    } op_t;

    state_t             state_reg;
    op_t                op_reg;
    q_item_t            item_reg;
    logic [31:0]        step_reg;
    logic [31:0]        rem_reg;
    logic [PT_W-1:0]    idx_reg;
    logic [PT_W-1:0]    nxt_reg;
    logic [31:0]        cur_x_reg;
    logic [31:0]        cur_y_reg;
    logic [32:0]        d_x_reg;
    logic [32:0]        d_y_reg;
    logic               axis_reg;
    logic [DVD_W-1:0]   prod_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DSR_W-1:0]   dsr_reg;
    logic [31:0]        pos_x_reg;
    logic [31:0]        pos_y_reg;
    logic [31:0]        vel_x_reg;
    logic [31:0]        vel_y_reg;
    logic               err_reg;
    logic               m_valid_reg;
    logic [31:0]        m_pos_x_reg;
    logic [31:0]        m_pos_y_reg;
    logic [31:0]        m_vel_x_reg;
    logic [31:0]        m_vel_y_reg;
    logic               m_status_reg;

    logic [31:0]        mem_x [DEPTH];
    logic [31:0]        mem_y [DEPTH];
    logic [31:0]        rd_x_reg;
    logic [31:0]        rd_y_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;

    logic               div_start;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic [DSR_W-1:0]   div_r;

    logic [32:0]        d_sel;
    logic [32:0]        mag;
    logic [31:0]        cur_sel;
    logic [31:0]        pos_val;
    logic [31:0]        vel_val;
    logic               out_free;

    wpi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dvd_reg),
        .divisor   (dsr_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign q_pop     = (state_reg == ST_IDLE) && !q_stat.empty;
    assign div_start = state_reg == ST_DIV;
    assign out_free  = !m_valid_reg || m_ready;

    // Waypoint store addressing
    always_comb begin
        wr_en   = state_reg == ST_WRITE;
        wr_addr = ADDR_W'(32'(item_reg.target) * 32'(MAX_POINTS)
                          + 32'(item_reg.point_index));
        rd_addr = ADDR_W'(32'(item_reg.target) * 32'(MAX_POINTS)
                          + 32'((state_reg == ST_RD_NXT) ? nxt_reg : idx_reg));
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= item_reg.coord_x;
            mem_y[wr_addr] <= item_reg.coord_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // Per-axis arithmetic
    always_comb begin
        d_sel   = axis_reg ? d_y_reg : d_x_reg;
        cur_sel = axis_reg ? cur_y_reg : cur_x_reg;
        mag     = d_sel[32] ? (~d_sel + 33'd1) : d_sel;
        // Offset stays within the segment, so low 32 bits suffice
        pos_val = d_sel[32] ? (cur_sel - div_q[31:0]) : (cur_sel + div_q[31:0]);
        if (d_sel[32]) begin
            vel_val = (div_q > DVD_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                          : (~div_q[31:0] + 32'd1);
        end else begin
            vel_val = (div_q > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_RESULT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_stat.empty) begin
                        item_reg <= head_item;
                        step_reg <= (step_period < STEP_MIN) ? STEP_ONE : step_period;
                        dvd_reg  <= DVD_W'(head_item.time_req);
                        op_reg   <= OP_TIME;
                        unique case (head_item.kind)
                            KIND_LOAD: state_reg <= ST_WRITE;
                            KIND_QERR: begin
                                err_reg   <= 1'b1;
                                pos_x_reg <= '0;
                                pos_y_reg <= '0;
                                vel_x_reg <= '0;
                                vel_y_reg <= '0;
                                state_reg <= ST_RESULT;
                            end
                            KIND_QRUN: begin
                                err_reg   <= 1'b0;
                                dsr_reg   <= (step_period < STEP_MIN) ? STEP_ONE
                                                                      : step_period;
                                state_reg <= ST_DIV;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_WRITE: state_reg <= ST_IDLE;
                ST_DIV:   state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (div_done) begin
                        unique case (op_reg)
                            OP_TIME: begin
                                rem_reg   <= div_r;
                                dvd_reg   <= DVD_W'(div_q[31:0]);
                                dsr_reg   <= DSR_W'(item_reg.len);
                                op_reg    <= OP_MOD;
                                state_reg <= ST_DIV;
                            end
                            OP_MOD: begin
                                idx_reg   <= div_r[PT_W-1:0];
                                state_reg <= ST_RD_CUR;
                            end
                            OP_POS: begin
                                if (axis_reg) pos_y_reg <= pos_val;
                                else          pos_x_reg <= pos_val;
                                dvd_reg   <= DVD_W'({mag, 16'h0000});
                                op_reg    <= OP_VEL;
                                state_reg <= ST_DIV;
                            end
                            OP_VEL: begin
                                if (axis_reg) begin
                                    vel_y_reg <= vel_val;
                                    state_reg <= ST_RESULT;
                                end else begin
                                    vel_x_reg <= vel_val;
                                    axis_reg  <= 1'b1;
                                    state_reg <= ST_MUL_LO;
                                end
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RD_CUR: begin
                    // Next point wraps to the first
                    nxt_reg   <= (LEN_MAX_W'(idx_reg) + LEN_MAX_W'(1) == item_reg.len)
                                 ? '0 : PT_W'(idx_reg + 1'b1);
                    state_reg <= ST_RD_NXT;
                end
                ST_RD_NXT: begin
                    cur_x_reg <= rd_x_reg;
                    cur_y_reg <= rd_y_reg;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    d_x_reg   <= {rd_x_reg[31], rd_x_reg} - {cur_x_reg[31], cur_x_reg};
                    d_y_reg   <= {rd_y_reg[31], rd_y_reg} - {cur_y_reg[31], cur_y_reg};
                    axis_reg  <= 1'b0;
                    state_reg <= ST_MUL_LO;
                end
                ST_MUL_LO: begin
                    prod_reg  <= DVD_W'(mag * rem_reg[15:0]);
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    dvd_reg   <= prod_reg + DVD_W'({49'(mag * rem_reg[31:16]), 16'h0000});
                    dsr_reg   <= step_reg;
                    op_reg    <= OP_POS;
                    state_reg <= ST_DIV;
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_pos_x_reg  <= pos_x_reg;
                        m_pos_y_reg  <= pos_y_reg;
                        m_vel_x_reg  <= vel_x_reg;
                        m_vel_y_reg  <= vel_y_reg;
                        m_status_reg <= err_reg ? STATUS_ERR : STATUS_OK;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_pos_x  = m_pos_x_reg;
    assign m_pos_y  = m_pos_y_reg;
    assign m_vel_x  = m_vel_x_reg;
    assign m_vel_y  = m_vel_y_reg;
    assign m_status = m_status_reg;

endmodule : wpi_back
`default_nettype wire

### rtl/waypoint_path_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_path_interpolator
// Closed-path piecewise linear waypoint interpolation in Q16.16.
// ----------------------------------------------------------------------------
// Loads write one waypoint into the store. A good query uses one shared
// radix-2 divider of 65 quotient bits that runs six times per query
// (time/step, segment mod length, then position and velocity for each axis),
// with waypoint reads, multiplies and an output step around the divisions.
// The front end accepts a beat every cycle while its 4-entry queue has room,
// so loads and queries keep arriving while a query is being worked out.
// No clearing pass is needed after reset: path lengths reset to zero.
module waypoint_path_interpolator
    import wpi_pkg::*;
#(
    parameter int NUM_TARGETS = 16,
    parameter int MAX_POINTS  = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_cmd,
    input  wire logic [TGT_IN_W-1:0] s_target,
    input  wire logic [PT_IN_W-1:0]  s_point_index,
    input  wire logic                s_last_point,
    input  wire logic [COORD_W-1:0]  s_coord_x,
    input  wire logic [COORD_W-1:0]  s_coord_y,
    input  wire logic [TIME_W-1:0]   s_time_req,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [COORD_W-1:0]       m_pos_x,
    output logic [COORD_W-1:0]       m_pos_y,
    output logic [COORD_W-1:0]       m_vel_x,
    output logic [COORD_W-1:0]       m_vel_y,
    output logic                     m_status
);

    logic [31:0] step_period_reg;
    logic        q_push;
    logic        q_pop;
    q_item_t     q_in;
    q_item_t     q_head;
    q_stat_t     q_stat;

    // Step register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_period_reg <= STEP_ONE;
        end else if (cfg_we) begin
            step_period_reg <= cfg_wdata;
        end
    end

    wpi_front #(
        .NUM_TARGETS (NUM_TARGETS),
        .MAX_POINTS  (MAX_POINTS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_target      (s_target),
        .s_point_index (s_point_index),
        .s_last_point  (s_last_point),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_time_req    (s_time_req),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    wpi_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head_item (q_head),
        .stat      (q_stat)
    );

    wpi_back #(
        .NUM_TARGETS (NUM_TARGETS),
        .MAX_POINTS  (MAX_POINTS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_period (step_period_reg),
        .head_item   (q_head),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_vel_x     (m_vel_x),
        .m_vel_y     (m_vel_y),
        .m_status    (m_status)
    );

    // Queue never overflows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    // Queue never underflows
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // Error results carry zeros
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STATUS_ERR)) |->
        (m_pos_x == '0 && m_pos_y == '0 && m_vel_x == '0 && m_vel_y == '0))
        else $error("error beat with nonzero payload");

endmodule : waypoint_path_interpolator
`default_nettype wire
